// ===== rtl/core/gne_pkg.sv =====
// Shared types, constants and offset tables for the grid neighbour enumerator.
// No dependencies; imported by gne_pos_unit, grid_neighbor_enumerator_top and the testbench.
`default_nettype none

package gne_pkg;

	// Map geometry
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAP_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(MAP_DEPTH);

	// Coordinates are 8 bits, so the usable grid never exceeds 256 either way
	localparam int COORD_W = 8;
	localparam int SIZE_W  = 9;
	localparam int W_CAP   = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
	localparam int H_CAP   = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

	// Request kinds (code 3 is unused and answered with found clear)
	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_ENUM  = 2'd1;
	localparam logic [1:0] FUNC_PROBE = 2'd2;

	// Diagonal gating modes
	localparam logic [1:0] DIAG_NEVER  = 2'd0;
	localparam logic [1:0] DIAG_BOTH   = 2'd1;
	localparam logic [1:0] DIAG_EITHER = 2'd2;
	localparam logic [1:0] DIAG_ALWAYS = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DIAG_MODE   = 2'd2;

	// Step codes: 0..3 sides N E S W, 4..7 diagonals NW NE SE SW, then the cell itself
	localparam logic [3:0] STEP_FIRST_NBR  = 4'd0;
	localparam logic [3:0] STEP_LAST_NBR   = 4'd7;
	localparam logic [3:0] STEP_CENTER     = 4'd8;

	// Position of one candidate cell as seen by the sequencer
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               in_grid;
		logic [ADDR_W-1:0]  addr;
	} cell_pos_t;

	// Column offset of a step
	function automatic logic signed [1:0] step_dx(input logic [3:0] step);
		logic signed [1:0] d;
		case (step)
			4'd1, 4'd5, 4'd6: d = 2'sb01;
			4'd3, 4'd4, 4'd7: d = 2'sb11;
			default:          d = 2'sb00;
		endcase
		return d;
	endfunction

	// Row offset of a step (north is row - 1)
	function automatic logic signed [1:0] step_dy(input logic [3:0] step);
		logic signed [1:0] d;
		case (step)
			4'd0, 4'd4, 4'd5: d = 2'sb11;
			4'd2, 4'd6, 4'd7: d = 2'sb01;
			default:          d = 2'sb00;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/grid_neighbor_enumerator_top.sv =====
// Top level of the grid neighbour enumerator: sequencer, configuration registers,
// result staging and the map RAM. Depends on gne_pkg, gne_ram and gne_pos_unit.
//
//   channel  dir  handshake                     payload
//   s_axis   in   s_axis_tvalid/s_axis_tready   tdata {new_walkable,cell_y,cell_x}, tuser func
//   m_axis   out  m_axis_tvalid/m_axis_tready   tdata {nbr_y,nbr_x}, tuser found, tlast is_last
//   cfg      in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// A write, probe or unused request runs from acceptance through an issue state, a map
// read and evaluation for a probe inside the grid, and a done state, before the next
// request is taken. A neighbour query walks eight steps through one position unit and
// one RAM read port: a skipped step only issues, a step that reads the map issues and
// then evaluates, and a done state ends the query. After reset a clearing pass sets
// all MAP_DEPTH map bits walkable, during which no request is taken; configuration
// writes are always taken. A stalled result output holds the sequencer at its next result.
`default_nettype none

module grid_neighbor_enumerator_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // [7:0] cell_x, [15:8] cell_y, [16] new_walkable
	input  wire logic [1:0]  s_axis_tuser,  // [1:0] func
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [7:0] nbr_x, [15:8] nbr_y
	output logic [0:0]       m_axis_tuser,  // [0] found
	output logic             m_axis_tlast,  // is_last
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [gne_pkg::SIZE_W-1:0] cfg_data
);

	import gne_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_ISSUE = 5'b00100,
		ST_EVAL  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   clr_cnt_q;
	logic [SIZE_W-1:0]   grid_w_q;
	logic [SIZE_W-1:0]   grid_h_q;
	logic [1:0]          diag_mode_q;

	logic [1:0]          func_q;
	logic [COORD_W-1:0]  base_x_q;
	logic [COORD_W-1:0]  base_y_q;
	logic                new_walk_q;
	logic [3:0]          step_q;
	logic [3:0]          sides_q;
	logic                rep_found_q;
	logic                pend_v_q;
	logic [COORD_W-1:0]  pend_x_q;
	logic [COORD_W-1:0]  pend_y_q;

	logic                m_valid_q;
	logic [COORD_W-1:0]  m_x_q;
	logic [COORD_W-1:0]  m_y_q;
	logic                m_found_q;
	logic                m_last_q;

	cell_pos_t           pos;
	logic                in_fire;
	logic                out_free;
	logic                is_enum;
	logic                side_a;
	logic                side_b;
	logic                diag_ok;
	logic                step_open;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [0:0]          ram_wdata;
	logic                ram_re;
	logic [0:0]          ram_rdata;
	logic                hit;
	logic                eval_stall;
	logic                push_pend;
	logic                done_fire;

	// Shared position unit
	gne_pos_unit u_pos (
		.base_x      (base_x_q),
		.base_y      (base_y_q),
		.step        (step_q),
		.grid_width  (grid_w_q),
		.grid_height (grid_h_q),
		.pos         (pos)
	);

	// Walkability map
	gne_ram #(
		.WIDTH (1),
		.DEPTH (MAP_DEPTH)
	) u_map (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (pos.addr),
		.rd_data (ram_rdata)
	);

	// Handshakes
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign is_enum       = (func_q == FUNC_ENUM);

	// Diagonal gate: diagonal j lies between side j-1 and side j
	always_comb begin
		side_a = sides_q[2'(step_q[1:0] + 2'd3)];
		side_b = sides_q[step_q[1:0]];
		case (diag_mode_q)
			DIAG_BOTH:   diag_ok = side_a && side_b;
			DIAG_EITHER: diag_ok = side_a || side_b;
			DIAG_ALWAYS: diag_ok = 1'b1;
			default:     diag_ok = 1'b0;
		endcase
		step_open = step_q[2] ? diag_ok : 1'b1;
	end

	// Map port control
	always_comb begin
		ram_we    = (state_q == ST_CLEAR) ||
		            ((state_q == ST_ISSUE) && (func_q == FUNC_WRITE) && pos.in_grid);
		ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : pos.addr;
		ram_wdata = (state_q == ST_CLEAR) ? 1'b1 : new_walk_q;
		ram_re    = (state_q == ST_ISSUE) && pos.in_grid &&
		            ((func_q == FUNC_PROBE) || (is_enum && step_open));
	end

	// Result staging
	assign hit        = ram_rdata[0];
	assign eval_stall = (state_q == ST_EVAL) && is_enum && hit && pend_v_q && !out_free;
	assign push_pend  = (state_q == ST_EVAL) && is_enum && hit && pend_v_q && out_free;
	assign done_fire  = (state_q == ST_DONE) && out_free;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q    <= SIZE_W'(256);
			grid_h_q    <= SIZE_W'(256);
			diag_mode_q <= DIAG_NEVER;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GRID_WIDTH:  grid_w_q    <= cfg_data;
				REG_GRID_HEIGHT: grid_h_q    <= cfg_data;
				REG_DIAG_MODE:   diag_mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (push_pend || done_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_valid_q && m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_pend) begin
			m_x_q     <= pend_x_q;
			m_y_q     <= pend_y_q;
			m_found_q <= 1'b1;
			m_last_q  <= 1'b0;
		end else if (done_fire) begin
			m_x_q     <= pend_v_q ? pend_x_q : base_x_q;
			m_y_q     <= pend_v_q ? pend_y_q : base_y_q;
			m_found_q <= pend_v_q ? 1'b1 : rep_found_q;
			m_last_q  <= 1'b1;
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = {m_y_q, m_x_q};
	assign m_axis_tuser[0] = m_found_q;
	assign m_axis_tlast    = m_last_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			pend_v_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == ADDR_W'(MAP_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						func_q      <= s_axis_tuser;
						base_x_q    <= s_axis_tdata[7:0];
						base_y_q    <= s_axis_tdata[15:8];
						new_walk_q  <= s_axis_tdata[16];
						sides_q     <= '0;
						rep_found_q <= 1'b0;
						pend_v_q    <= 1'b0;
						step_q      <= (s_axis_tuser == FUNC_ENUM) ? STEP_FIRST_NBR
						                                           : STEP_CENTER;
						state_q     <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					case (func_q)
						FUNC_WRITE: begin
							rep_found_q <= pos.in_grid && new_walk_q;
							state_q     <= ST_DONE;
						end
						FUNC_PROBE: begin
							state_q <= pos.in_grid ? ST_EVAL : ST_DONE;
						end
						FUNC_ENUM: begin
							if (ram_re) begin
								state_q <= ST_EVAL;
							end else if (step_q == STEP_LAST_NBR) begin
								state_q <= ST_DONE;
							end else begin
								step_q <= step_q + 4'd1;
							end
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_EVAL: begin
					if (!is_enum) begin
						rep_found_q <= hit;
						state_q     <= ST_DONE;
					end else if (!eval_stall) begin
						// record the side, keep a found neighbour back until the next one
						if (!step_q[2]) begin
							sides_q[step_q[1:0]] <= hit;
						end
						if (hit) begin
							pend_v_q <= 1'b1;
							pend_x_q <= pos.x;
							pend_y_q <= pos.y;
						end
						if (step_q == STEP_LAST_NBR) begin
							state_q <= ST_DONE;
						end else begin
							step_q  <= step_q + 4'd1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks

	// A held-back neighbour only exists while a query is in progress
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (state_q == ST_ISSUE || state_q == ST_EVAL || state_q == ST_DONE))
		else $error("pending neighbour outside a query");

	// Nothing is taken or delivered during the clearing pass
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!m_valid_q && !s_axis_tready))
		else $error("activity during map clearing");

	// Only the closing result of a request may carry found clear
	a_nofind_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
		else $error("found clear on a non-final result");

	// Evaluation follows a map read issued the cycle before, or a stalled evaluation
	a_eval_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> ($past(ram_re) || $past(state_q) == ST_EVAL))
		else $error("evaluation without a map read");

endmodule

`default_nettype wire

// ===== rtl/core/gne_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the walkability map.
`default_nettype none

module gne_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port, holds its value between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/gne_pos_unit.sv =====
// Shared position unit: offsets the current cell by one step, checks the grid bounds
// and forms the map address. Depends on gne_pkg.
`default_nettype none

module gne_pos_unit (
	input  wire logic [gne_pkg::COORD_W-1:0] base_x,
	input  wire logic [gne_pkg::COORD_W-1:0] base_y,
	input  wire logic [3:0]                  step,
	input  wire logic [gne_pkg::SIZE_W-1:0]  grid_width,
	input  wire logic [gne_pkg::SIZE_W-1:0]  grid_height,
	output gne_pkg::cell_pos_t               pos
);

	import gne_pkg::*;

	logic [SIZE_W-1:0]  eff_w;
	logic [SIZE_W-1:0]  eff_h;
	logic signed [1:0]  dx;
	logic signed [1:0]  dy;
	logic signed [9:0]  nx;
	logic signed [9:0]  ny;

	// Effective grid size, capped by the map and the coordinate width
	always_comb begin
		eff_w = (grid_width > SIZE_W'(W_CAP)) ? SIZE_W'(W_CAP) : grid_width;
		eff_h = (grid_height > SIZE_W'(H_CAP)) ? SIZE_W'(H_CAP) : grid_height;
	end

	// Candidate coordinates, -1 .. 256
	always_comb begin
		dx = step_dx(step);
		dy = step_dy(step);
		nx = $signed({2'b00, base_x}) + $signed({{8{dx[1]}}, dx});
		ny = $signed({2'b00, base_y}) + $signed({{8{dy[1]}}, dy});
	end

	// Bounds check and row-major address
	always_comb begin
		pos.x       = nx[COORD_W-1:0];
		pos.y       = ny[COORD_W-1:0];
		pos.in_grid = !nx[9] && !ny[9] && (nx[8:0] < eff_w) && (ny[8:0] < eff_h);
		pos.addr    = ADDR_W'(ADDR_W'(ny[8:0]) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(nx[8:0]);
	end

endmodule

`default_nettype wire

// ===== tb/grid_neighbor_enumerator_top_tb.sv =====
// Self-checking testbench for grid_neighbor_enumerator_top: drives requests and
// configuration writes, predicts every result with a walkability scoreboard.
// Depends on gne_pkg and the grid_neighbor_enumerator_top RTL.

module grid_neighbor_enumerator_top_tb;

	import gne_pkg::*;

	// Request code that the block leaves unused
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	// Cycles without any accepted transfer before the run is abandoned
	localparam int STALL_LIMIT = 200000;
	// Quiet cycles spent after the last result has come
	localparam int SETTLE_CYCLES = 24;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic       found;
		logic       last;
	} nbr_result_t;

	// Walkability scoreboard: own copy of the map and registers, queue of results due
	class nbr_scoreboard;
		bit          walk [MAP_DEPTH];
		int          grid_w;
		int          grid_h;
		logic [1:0]  diag;
		nbr_result_t due_results [$];
		int          failures;

		function new();
			foreach (walk[i]) walk[i] = 1'b1;
			grid_w = 256;
			grid_h = 256;
			diag = DIAG_NEVER;
			failures = 0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void set_register(logic [1:0] idx, logic [8:0] val);
			case (idx)
				REG_GRID_WIDTH:  grid_w = int'(val);
				REG_GRID_HEIGHT: grid_h = int'(val);
				REG_DIAG_MODE:   diag = val[1:0];
				default: ;
			endcase
		endfunction

		function bit in_grid(int x, int y);
			int w;
			int h;
			w = (grid_w > W_CAP) ? W_CAP : grid_w;
			h = (grid_h > H_CAP) ? H_CAP : grid_h;
			return x >= 0 && x < w && y >= 0 && y < h;
		endfunction

		function bit walkable_at(int x, int y);
			if (!in_grid(x, y)) return 1'b0;
			return walk[y * MAX_WIDTH + x];
		endfunction

		// Offsets: 0..3 sides N E S W, 4..7 diagonals NW NE SE SW
		function void step_offset(int k, output int ox, output int oy);
			case (k)
				0: begin ox = 0;  oy = -1; end
				1: begin ox = 1;  oy = 0;  end
				2: begin ox = 0;  oy = 1;  end
				3: begin ox = -1; oy = 0;  end
				4: begin ox = -1; oy = -1; end
				5: begin ox = 1;  oy = -1; end
				6: begin ox = 1;  oy = 1;  end
				default: begin ox = -1; oy = 1; end
			endcase
		endfunction

		function void add_result(int x, int y, bit found, bit last);
			nbr_result_t r;
			r.x = x[7:0];
			r.y = y[7:0];
			r.found = found;
			r.last = last;
			due_results = {due_results, r};
		endfunction

		// Work out the results of one accepted request and update the map
		function void note_request(logic [1:0] fn, logic [7:0] x, logic [7:0] y, logic nw);
			int cx;
			int cy;
			int ox;
			int oy;
			int n;
			bit side [4];
			bit a;
			bit b;
			bit gate;
			nbr_result_t r;
			cx = int'(x);
			cy = int'(y);
			case (fn)
				FUNC_WRITE: begin
					if (in_grid(cx, cy)) walk[cy * MAX_WIDTH + cx] = nw;
					add_result(cx, cy, walkable_at(cx, cy), 1'b1);
				end
				FUNC_PROBE: add_result(cx, cy, walkable_at(cx, cy), 1'b1);
				FUNC_ENUM: begin
					n = 0;
					for (int k = 0; k < 4; k++) begin
						step_offset(k, ox, oy);
						side[k] = walkable_at(cx + ox, cy + oy);
						if (side[k]) begin
							add_result(cx + ox, cy + oy, 1'b1, 1'b0);
							n++;
						end
					end
					// a diagonal sits between the previous side and this one
					for (int k = 0; k < 4; k++) begin
						a = side[(k + 3) % 4];
						b = side[k];
						case (diag)
							DIAG_BOTH:   gate = a && b;
							DIAG_EITHER: gate = a || b;
							DIAG_ALWAYS: gate = 1'b1;
							default:     gate = 1'b0;
						endcase
						step_offset(k + 4, ox, oy);
						if (gate && walkable_at(cx + ox, cy + oy)) begin
							add_result(cx + ox, cy + oy, 1'b1, 1'b0);
							n++;
						end
					end
					if (n == 0) begin
						add_result(cx, cy, 1'b0, 1'b1);
					end else begin
						r = due_results.pop_back();
						r.last = 1'b1;
						due_results = {due_results, r};
					end
				end
				default: add_result(cx, cy, 1'b0, 1'b1);
			endcase
		endfunction

		// Compare one accepted result with the oldest one due
		function void check_result(logic [7:0] x, logic [7:0] y, logic found, logic last);
			nbr_result_t e;
			if (due_results.size() == 0) begin
				$error("result (%0d,%0d) with no request outstanding", x, y);
				failures++;
				return;
			end
			e = due_results.pop_front();
			if (x !== e.x) begin
				$error("nbr_x expected %0d got %0d", e.x, x);
				failures++;
			end
			if (y !== e.y) begin
				$error("nbr_y expected %0d got %0d", e.y, y);
				failures++;
			end
			if (found !== e.found) begin
				$error("found expected %0d got %0d", e.found, found);
				failures++;
			end
			if (last !== e.last) begin
				$error("is_last expected %0d got %0d", e.last, last);
				failures++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [SIZE_W-1:0] cfg_data;

	nbr_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	grid_neighbor_enumerator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock, period 2
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Result side back-pressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Result checking
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tuser[0],
				m_axis_tlast);
	end

	// Watchdog: abandon the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One request, with random idle cycles before it
	task automatic send_request(input logic [1:0] fn, input logic [7:0] x,
			input logic [7:0] y, input logic nw);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, nw, y, x};
		s_axis_tuser <= fn;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(fn, x, y, nw);
	endtask

	// Stop sending and wait until every result due has come, then let the block settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_register(idx, val);
	endtask

	// New grid size and diagonal mode; called with the block idle, but first just after reset during the clearing pass
	task automatic write_settings(input logic [8:0] w, input logic [8:0] h,
			input logic [1:0] mode);
		write_reg(REG_GRID_WIDTH, w);
		write_reg(REG_GRID_HEIGHT, h);
		write_reg(REG_DIAG_MODE, mode);
		cfg_valid <= 1'b0;
	endtask

	// Mostly inside or just past the grid, sometimes on a border, sometimes anywhere
	function automatic logic [7:0] pick_coord(input int span);
		int v;
		int r;
		r = $urandom_range(9);
		if (r < 2) v = $urandom_range(255);
		else if (r == 2) v = $urandom_range(1) ? 0 : span - 1;
		else v = $urandom_range(span);
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v[7:0];
	endfunction

	task automatic random_requests(input int count, input int w_span, input int h_span);
		int r;
		logic [1:0] fn;
		for (int i = 0; i < count; i++) begin
			// hold off once per phase until the block has caught up
			if (i == count / 2) drain();
			r = $urandom_range(99);
			if (r < 30) fn = FUNC_WRITE;
			else if (r < 75) fn = FUNC_ENUM;
			else if (r < 95) fn = FUNC_PROBE;
			else fn = FUNC_UNUSED;
			send_request(fn, pick_coord(w_span), pick_coord(h_span),
				1'($urandom_range(1)));
		end
	endtask

	task automatic run_phase(input int w, input int h, input logic [1:0] mode,
			input int send_pct, input int recv_pct, input int count);
		drain();
		write_settings(9'(w), 9'(h), mode);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		random_requests(count, (w > 256) ? 256 : w, (h > 256) ? 256 : h);
	endtask

	initial begin
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= FUNC_WRITE;
		cfg_valid <= 1'b0;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data <= '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full-size grid: far corners, clearing a cell, unused code
		write_settings(9'd256, 9'd256, DIAG_NEVER);
		recv_stall_pct = 45;
		send_request(FUNC_PROBE, 8'd0, 8'd0, 1'b0);
		send_request(FUNC_PROBE, 8'd255, 8'd255, 1'b1);
		send_request(FUNC_WRITE, 8'd255, 8'd255, 1'b0);
		send_request(FUNC_ENUM, 8'd255, 8'd254, 1'b0);
		send_request(FUNC_UNUSED, 8'd170, 8'd85, 1'b1);
		send_request(FUNC_WRITE, 8'd255, 8'd255, 1'b1);

		// Small grid: write outside ignored, corners, query from outside, empty query
		drain();
		write_settings(9'd5, 9'd4, DIAG_BOTH);
		send_request(FUNC_WRITE, 8'd9, 8'd2, 1'b0);
		send_request(FUNC_PROBE, 8'd9, 8'd2, 1'b0);
		send_request(FUNC_ENUM, 8'd0, 8'd0, 1'b0);
		send_request(FUNC_WRITE, 8'd1, 8'd0, 1'b0);
		send_request(FUNC_ENUM, 8'd0, 8'd0, 1'b0);
		send_request(FUNC_ENUM, 8'd4, 8'd3, 1'b0);
		send_request(FUNC_ENUM, 8'd5, 8'd2, 1'b0);
		send_request(FUNC_ENUM, 8'd200, 8'd200, 1'b0);

		// Remaining diagonal modes around the blocked cell
		drain();
		write_settings(9'd5, 9'd4, DIAG_EITHER);
		send_request(FUNC_ENUM, 8'd0, 8'd1, 1'b0);
		send_request(FUNC_ENUM, 8'd2, 8'd1, 1'b0);
		drain();
		write_settings(9'd5, 9'd4, DIAG_ALWAYS);
		send_request(FUNC_ENUM, 8'd1, 8'd1, 1'b0);

		// Single-cell grid, then an oversized width with zero height
		drain();
		write_settings(9'd1, 9'd1, DIAG_ALWAYS);
		send_request(FUNC_ENUM, 8'd0, 8'd0, 1'b0);
		send_request(FUNC_PROBE, 8'd0, 8'd0, 1'b0);
		drain();
		write_settings(9'd511, 9'd0, DIAG_ALWAYS);
		send_request(FUNC_PROBE, 8'd255, 8'd0, 1'b0);
		send_request(FUNC_ENUM, 8'd10, 8'd10, 1'b0);
		send_request(FUNC_WRITE, 8'd3, 8'd0, 1'b1);

		// Random phases over sizes, modes and idling patterns
		run_phase(8, 8, DIAG_BOTH, 0, 0, 30);
		run_phase(6, 5, DIAG_EITHER, 45, 0, 25);
		run_phase(1, 7, DIAG_ALWAYS, 0, 45, 15);
		run_phase(16, 3, DIAG_NEVER, 18, 18, 20);
		run_phase(256, 256, DIAG_ALWAYS, 0, 0, 15);
		run_phase(511, 2, DIAG_BOTH, 0, 45, 15);
		run_phase(7, 7, DIAG_ALWAYS, 18, 18, 30);

		drain();
		if (sb.failures == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== grid_neighbor_enumerator_top.f =====
rtl/core/gne_pkg.sv
rtl/core/gne_ram.sv
rtl/core/gne_pos_unit.sv
rtl/core/grid_neighbor_enumerator_top.sv
tb/grid_neighbor_enumerator_top_tb.sv
